// File: design/dda_line_rasterizer_core_defines.svh
// ----------------------------------------------------------------------------
// DDA line rasterizer assertion macros
// Shared concurrent assertion forms for the rasterizer modules.
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_CORE_DEFINES_SVH
`define DDA_LINE_RASTERIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DLR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DLR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dlr_pkg.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Default sizes, item codes and the divider status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlr_pkg;

  localparam int COORD_BITS_DEF    = 12;
  localparam int FRACTION_BITS_DEF = 16;

  // action codes carried on s_tuser
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: design/dlr_div.sv
// ----------------------------------------------------------------------------
// DDA increment divider
// Restoring divider, one quotient bit per cycle: (num << F) / den, num <= den.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlr_div
  import dlr_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [COORD_BITS-1:0]    num,
  input  logic [COORD_BITS-1:0]    den,
  output div_stat_t                stat,
  output logic [FRACTION_BITS:0]   quot
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [COORD_BITS:0]   rem;
  logic [COORD_BITS-1:0] den_r;

  logic [COORD_BITS:0]   trial;
  logic                  ge;

  // first step compares num itself (integer bit), later steps shift in a zero
  always_comb begin
    trial = (cnt == '0) ? rem : {rem[COORD_BITS-1:0], 1'b0};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= {1'b0, num};
        den_r <= den;
        quot  <= '0;
      end else if (busy) begin
        rem  <= ge ? (trial - {1'b0, den_r}) : trial;
        quot <= {quot[FRACTION_BITS-1:0], ge};
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(FRACTION_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: design/dda_line_rasterizer_core.sv
// Start item: setup, then two serial divisions of FRACTION_BITS + 1 steps each on the one
//   shared divider, each with a launch and a done strobe, then the emit of the start pixel.
//   A zero-length line skips the divisions.
// Advance item: registered at accept; one advance per cycle unless the output stalls.
// s_tready is low from a start accept until its pixel is loaded, and while a pixel waits.
// Synchronous active-high reset clears the sequencer, line_active, steps and output valid.
// ----------------------------------------------------------------------------
// DDA line rasterizer core
// Fixed-point digital differential analyzer: one pixel per start item and per advance item of an active line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dda_line_rasterizer_core_defines.svh"

module dda_line_rasterizer_core
  import dlr_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave side: tdata = x_start, y_start, x_end, y_end (lowest bits first)
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]   s_tdata,
  // tuser = action (ACT_START / ACT_ADVANCE)
  input  logic                                s_tuser,
  // master side: tdata = pixel_x, pixel_y (lowest bits first); tlast = last_pixel
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
  output logic                                m_tlast
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRACTION_BITS;
  // position register carries position + 0.5, one guard bit above C.F
  localparam int POS_W = C + F + 1;
  // increment magnitude is at most 1.0
  localparam int INC_W = F + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_X,
    ST_DIV_Y,
    ST_EMIT
  } state_t;

  state_t state;

  // line state
  logic signed [POS_W-1:0] x_pos;
  logic signed [POS_W-1:0] y_pos;
  logic signed [INC_W-1:0] x_inc;
  logic signed [INC_W-1:0] y_inc;
  logic [C-1:0]            steps_left;
  logic                    line_active;

  // start bookkeeping
  logic signed [C:0]       dx;
  logic signed [C:0]       dy;
  logic [C-1:0]            ay;
  logic [C-1:0]            span;
  logic                    zero_len;

  // divider hookup
  logic                    div_start;
  logic [C-1:0]            div_num;
  logic [C-1:0]            div_den;
  div_stat_t               div_stat;
  logic [F:0]              div_quot;

  // output register
  logic [C-1:0]            px;
  logic [C-1:0]            py;

  // item fields
  logic signed [C-1:0]     in_xs;
  logic signed [C-1:0]     in_ys;
  logic signed [C-1:0]     in_xe;
  logic signed [C-1:0]     in_ye;

  logic                    out_free;
  logic                    accept;
  logic signed [POS_W-1:0] x_pos_adv;
  logic signed [POS_W-1:0] y_pos_adv;
  logic [C:0]              dx_neg;
  logic [C:0]              dy_neg;
  logic [C-1:0]            ax_c;
  logic [C-1:0]            ay_c;
  logic [C-1:0]            span_c;
  logic signed [INC_W-1:0] q_ext;

  assign in_xs = s_tdata[C-1:0];
  assign in_ys = s_tdata[2*C-1:C];
  assign in_xe = s_tdata[3*C-1:2*C];
  assign in_ye = s_tdata[4*C-1:3*C];

  // round to pixel: truncate (pos + 0.5) toward zero; v already holds pos + 0.5
  function automatic logic [C-1:0] round_pixel(input logic signed [POS_W-1:0] v);
    logic signed [POS_W-1:0] t;
    logic                    frac_nz;
    t       = v >>> F;
    frac_nz = |v[F-1:0];
    if (v[POS_W-1] && frac_nz) begin
      round_pixel = t[C-1:0] + C'(1);
    end else begin
      round_pixel = t[C-1:0];
    end
  endfunction

  // output slot frees up when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    x_pos_adv = x_pos + {{(POS_W-INC_W){x_inc[INC_W-1]}}, x_inc};
    y_pos_adv = y_pos + {{(POS_W-INC_W){y_inc[INC_W-1]}}, y_inc};
    dx_neg    = -dx;
    dy_neg    = -dy;
    ax_c      = dx[C] ? dx_neg[C-1:0] : dx[C-1:0];
    ay_c      = dy[C] ? dy_neg[C-1:0] : dy[C-1:0];
    span_c    = (ax_c > ay_c) ? ax_c : ay_c;
    q_ext     = {1'b0, div_quot};
  end

  dlr_div #(
    .COORD_BITS    (C),
    .FRACTION_BITS (F)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      line_active <= 1'b0;
      steps_left  <= '0;
      div_start   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == ACT_START) begin
              // abandon any line; position starts at coordinate + 0.5
              line_active <= 1'b0;
              x_pos <= {in_xs[C-1], in_xs, 1'b1, {(F-1){1'b0}}};
              y_pos <= {in_ys[C-1], in_ys, 1'b1, {(F-1){1'b0}}};
              dx    <= {in_xe[C-1], in_xe} - {in_xs[C-1], in_xs};
              dy    <= {in_ye[C-1], in_ye} - {in_ys[C-1], in_ys};
              state <= ST_SETUP;
            end else if (line_active) begin
              x_pos      <= x_pos_adv;
              y_pos      <= y_pos_adv;
              steps_left <= steps_left - C'(1);
              px         <= round_pixel(x_pos_adv);
              py         <= round_pixel(y_pos_adv);
              m_tlast    <= (steps_left == C'(1));
              m_tvalid   <= 1'b1;
              if (steps_left == C'(1)) begin
                line_active <= 1'b0;
              end
            end
          end
        end

        ST_SETUP: begin
          ay       <= ay_c;
          span     <= span_c;
          zero_len <= (span_c == '0);
          if (span_c == '0) begin
            x_inc <= '0;
            y_inc <= '0;
            state <= ST_EMIT;
          end else begin
            div_start <= 1'b1;
            div_num   <= ax_c;
            div_den   <= span_c;
            state     <= ST_DIV_X;
          end
        end

        ST_DIV_X: begin
          if (div_stat.done) begin
            x_inc     <= dx[C] ? -q_ext : q_ext;
            div_start <= 1'b1;
            div_num   <= ay;
            div_den   <= span;
            state     <= ST_DIV_Y;
          end
        end

        ST_DIV_Y: begin
          if (div_stat.done) begin
            y_inc <= dy[C] ? -q_ext : q_ext;
            state <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          // start pixel; a zero-length line ends here
          if (out_free) begin
            px          <= round_pixel(x_pos);
            py          <= round_pixel(y_pos);
            m_tlast     <= zero_len;
            m_tvalid    <= 1'b1;
            line_active <= !zero_len;
            steps_left  <= span;
            state       <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    m_tdata          = '0;
    m_tdata[C-1:0]   = px;
    m_tdata[2*C-1:C] = py;
  end

  // the last pixel of a line leaves no line behind it
  `DLR_ASSERT_IMP(a_last_ends_line, clk, rst, m_tvalid && m_tlast, !line_active,
    "last pixel shown while line still active")
  // an active line always has advances left
  `DLR_ASSERT_IMP(a_active_has_steps, clk, rst, line_active, steps_left != '0,
    "active line with no steps left")
  // the divider only runs under the division states
  `DLR_ASSERT_IMP(a_div_in_seq, clk, rst, div_stat.busy,
    state == ST_DIV_X || state == ST_DIV_Y, "divider busy outside division")

endmodule
